### hdl/lmfe_pkg.sv
`default_nettype none

package lmfe_pkg;

	localparam int MAX_DATA_DEF = 8;

	// Header and diagnostic frame constants
	localparam logic [7:0] BREAK_BYTE   = 8'h00;
	localparam logic [7:0] SYNC_BYTE    = 8'h55;
	localparam logic [7:0] PID_DIAG_REQ = 8'h3C;
	localparam logic [7:0] PID_DIAG_RSP = 8'h7D;
	localparam logic [7:0] BYTE_ONE     = 8'h01;

	// Request modes
	localparam logic [2:0] MODE_START_REQ = 3'd0;
	localparam logic [2:0] MODE_START_RSP = 3'd1;
	localparam logic [2:0] MODE_DATA      = 3'd2;
	localparam logic [2:0] MODE_RX        = 3'd3;
	localparam logic [2:0] MODE_TIMEOUT   = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_RX     = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Frame status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_STATE   = 3'd1;
	localparam logic [2:0] ST_TIMEOUT = 3'd2;
	localparam logic [2:0] ST_ECHO    = 3'd3;
	localparam logic [2:0] ST_CHK     = 3'd4;

	// Sticky error bits
	localparam logic [3:0] ERR_NONE    = 4'b0000;
	localparam logic [3:0] ERR_STATE   = 4'b0001;
	localparam logic [3:0] ERR_TIMEOUT = 4'b0010;
	localparam logic [3:0] ERR_ECHO    = 4'b0100;
	localparam logic [3:0] ERR_CHK     = 4'b1000;

	typedef struct packed {
		logic [7:0] add_a;
		logic [7:0] add_b;
		logic [7:0] cmp_x;
		logic [7:0] cmp_y;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] sum;
		logic       eq;
	} alu_rsp_t;

	function automatic logic [7:0] pid_of(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

endpackage

`default_nettype wire

### hdl/lin_master_frame_engine.sv
`default_nettype none

// LIN master frame engine. Each request on the slave stream is decoded by a small
// sequencer that drives one shared add/compare unit and a frame byte RAM of
// MAX_DATA+4 entries; s_axis_tready is low while a request is in work. An echoed
// byte is read back from the RAM first and compared. Once a response frame's
// checksum byte checks out, its data bytes are read back from the RAM and sent,
// followed by a status. Results leave through one output register, so a stalled
// m_axis_tready holds the sequencer.
// The checksum is classic when lin_version is 0 or the PID is 0x3C or 0x7D, and
// enhanced (seeded with the PID) otherwise. error_flags are sticky until reset.
module lin_master_frame_engine #(
	parameter int MAX_DATA = lmfe_pkg::MAX_DATA_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,     // lin_version
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata, // frame_id[5:0], data_len[9:6], byte_value[17:10]
	input  wire logic [2:0]  s_axis_tuser, // mode[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata, // out_byte[7:0], status[10:8], error_flags[14:11]
	output logic [1:0]       m_axis_tuser, // kind[1:0]
	output logic             m_axis_tlast
);

	localparam int DEPTH = MAX_DATA + 4;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {PH_IDLE, PH_COLLECT, PH_FRAME} phase_t;
	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_HDR, S_DATA, S_CHK, S_ECHO, S_OUTRD, S_OUTEM, S_STAT
	} state_t;

	state_t     state_q;
	phase_t     phase_q;
	logic       lin_version_q;
	logic       is_req_q;
	logic [3:0] len_q;
	logic [3:0] pos_q;
	logic [3:0] cnt_q;
	logic [7:0] sum_q;
	logic [3:0] sticky_q;
	logic [2:0] mode_q;
	logic [5:0] id_q;
	logic [3:0] in_len_q;
	logic [7:0] byte_q;
	logic [2:0] stat_q;
	logic [3:0] flag_q;

	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic [2:0] out_status_q;
	logic [3:0] out_flags_q;
	logic       out_last_q;

	lmfe_pkg::alu_req_t alu_req;
	lmfe_pkg::alu_rsp_t alu_rsp;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic       out_free;
	logic       emit;
	logic [1:0] emit_kind;
	logic [7:0] emit_byte;
	logic [2:0] emit_status;
	logic [3:0] emit_flag;
	logic       emit_last;

	logic [3:0] in_len;
	logic [3:0] frame_end;
	logic [7:0] pid;
	logic [7:0] sum_seed;
	logic [3:0] pos_inc;
	logic [3:0] cnt_inc;
	logic       dec_store;

	lmfe_csum u_csum (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	lmfe_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_flags_q, out_status_q, out_byte_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign in_len    = (s_axis_tdata[9:6] > 4'(MAX_DATA)) ? 4'(MAX_DATA) : s_axis_tdata[9:6];
	assign frame_end = len_q + 4'd3;
	assign pid       = lmfe_pkg::pid_of(id_q);
	assign sum_seed  = (lin_version_q && pid != lmfe_pkg::PID_DIAG_REQ
			&& pid != lmfe_pkg::PID_DIAG_RSP) ? pid : 8'h00;
	assign pos_inc   = pos_q + 4'd1;
	assign cnt_inc   = cnt_q + 4'd1;

	// Response data byte: store and accumulate, no result
	assign dec_store = (state_q == S_DEC) && (mode_q == lmfe_pkg::MODE_RX)
			&& (phase_q == PH_FRAME) && !is_req_q && (pos_q >= 4'd3)
			&& (pos_q < frame_end);

	always_comb begin
		alu_req.add_a = sum_q;
		alu_req.add_b = byte_q;
		alu_req.cmp_x = byte_q;
		alu_req.cmp_y = (state_q == S_ECHO) ? ram_rdata : ~sum_q;

		emit        = 1'b0;
		emit_kind   = lmfe_pkg::KIND_TX;
		emit_byte   = 8'h00;
		emit_status = lmfe_pkg::ST_OK;
		emit_flag   = lmfe_pkg::ERR_NONE;
		emit_last   = 1'b0;

		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = byte_q;
		ram_raddr = pos_q[AW-1:0];

		unique case (state_q)
			S_DEC: begin
				ram_we = dec_store;
			end
			S_HDR: begin
				emit = 1'b1;
				unique case (cnt_q)
					4'd0:    emit_byte = lmfe_pkg::BREAK_BYTE;
					4'd1:    emit_byte = lmfe_pkg::SYNC_BYTE;
					default: emit_byte = pid;
				endcase
				emit_last = (cnt_q == 4'd2) && !(is_req_q && len_q == 4'd0);
				ram_we    = out_free;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = emit_byte;
			end
			S_DATA: begin
				emit      = 1'b1;
				emit_byte = byte_q;
				emit_last = (pos_inc < len_q);
				ram_we    = out_free;
				ram_waddr = pos_inc[AW-1:0] + AW'(2);
			end
			S_CHK: begin
				emit      = 1'b1;
				emit_byte = ~sum_q;
				emit_last = 1'b1;
				ram_we    = out_free;
				ram_waddr = frame_end[AW-1:0];
				ram_wdata = ~sum_q;
			end
			S_OUTRD, S_OUTEM: begin
				ram_raddr = cnt_q[AW-1:0] + AW'(3);
				if (state_q == S_OUTEM) begin
					emit      = 1'b1;
					emit_kind = lmfe_pkg::KIND_RX;
					emit_byte = ram_rdata;
				end
			end
			S_STAT: begin
				emit        = 1'b1;
				emit_kind   = lmfe_pkg::KIND_STATUS;
				emit_status = stat_q;
				emit_flag   = flag_q;
				emit_last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_IDLE;
			lin_version_q <= 1'b1;
			is_req_q      <= 1'b0;
			len_q         <= '0;
			pos_q         <= '0;
			cnt_q         <= '0;
			sum_q         <= '0;
			sticky_q      <= '0;
			mode_q        <= '0;
			id_q          <= '0;
			in_len_q      <= '0;
			byte_q        <= '0;
			stat_q        <= lmfe_pkg::ST_OK;
			flag_q        <= lmfe_pkg::ERR_NONE;
			out_valid_q   <= 1'b0;
			out_kind_q    <= lmfe_pkg::KIND_TX;
			out_byte_q    <= '0;
			out_status_q  <= lmfe_pkg::ST_OK;
			out_flags_q   <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				lin_version_q <= cfg_data;
			end

			// Drop the result once taken, load the next one when free
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit && out_free) begin
				out_valid_q  <= 1'b1;
				out_kind_q   <= emit_kind;
				out_byte_q   <= emit_byte;
				out_status_q <= emit_status;
				out_flags_q  <= sticky_q | emit_flag;
				out_last_q   <= emit_last;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						mode_q   <= s_axis_tuser;
						id_q     <= s_axis_tdata[5:0];
						in_len_q <= in_len;
						byte_q   <= s_axis_tdata[17:10];
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					stat_q  <= lmfe_pkg::ST_STATE;
					flag_q  <= lmfe_pkg::ERR_STATE;
					state_q <= S_IDLE;
					priority if (mode_q == lmfe_pkg::MODE_START_REQ
							|| mode_q == lmfe_pkg::MODE_START_RSP) begin
						if (phase_q != PH_IDLE) begin
							state_q <= S_STAT;
						end else begin
							is_req_q <= (mode_q == lmfe_pkg::MODE_START_REQ);
							len_q    <= in_len_q;
							pos_q    <= '0;
							cnt_q    <= '0;
							sum_q    <= sum_seed;
							state_q  <= S_HDR;
						end
					end else if (mode_q == lmfe_pkg::MODE_DATA) begin
						if (phase_q != PH_COLLECT || !is_req_q || pos_q >= len_q) begin
							state_q <= S_STAT;
						end else begin
							state_q <= S_DATA;
						end
					end else if (mode_q == lmfe_pkg::MODE_RX) begin
						priority if (phase_q != PH_FRAME || pos_q > frame_end) begin
							state_q <= S_STAT;
						end else if (is_req_q || pos_q < 4'd3) begin
							state_q <= S_ECHO;
						end else if (pos_q < frame_end) begin
							sum_q <= alu_rsp.sum;
							pos_q <= pos_inc;
						end else if (!alu_rsp.eq) begin
							stat_q  <= lmfe_pkg::ST_CHK;
							flag_q  <= lmfe_pkg::ERR_CHK;
							state_q <= S_STAT;
						end else begin
							cnt_q  <= '0;
							stat_q <= lmfe_pkg::ST_OK;
							flag_q <= lmfe_pkg::ERR_NONE;
							state_q <= (len_q == 4'd0) ? S_STAT : S_OUTRD;
						end
					end else if (mode_q == lmfe_pkg::MODE_TIMEOUT) begin
						if (phase_q != PH_IDLE) begin
							stat_q  <= lmfe_pkg::ST_TIMEOUT;
							flag_q  <= lmfe_pkg::ERR_TIMEOUT;
							state_q <= S_STAT;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_HDR: begin
					if (out_free) begin
						if (cnt_q == 4'd2) begin
							priority if (is_req_q && len_q != 4'd0) begin
								phase_q <= PH_COLLECT;
								state_q <= S_IDLE;
							end else if (is_req_q) begin
								state_q <= S_CHK;
							end else begin
								phase_q <= PH_FRAME;
								state_q <= S_IDLE;
							end
						end else begin
							cnt_q <= cnt_inc;
						end
					end
				end
				S_DATA: begin
					if (out_free) begin
						sum_q   <= alu_rsp.sum;
						pos_q   <= pos_inc;
						state_q <= (pos_inc >= len_q) ? S_CHK : S_IDLE;
					end
				end
				S_CHK: begin
					if (out_free) begin
						phase_q <= PH_FRAME;
						pos_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_ECHO: begin
					priority if (!alu_rsp.eq) begin
						stat_q  <= lmfe_pkg::ST_ECHO;
						flag_q  <= lmfe_pkg::ERR_ECHO;
						state_q <= S_STAT;
					end else if (is_req_q && pos_q == frame_end) begin
						stat_q  <= lmfe_pkg::ST_OK;
						flag_q  <= lmfe_pkg::ERR_NONE;
						state_q <= S_STAT;
					end else begin
						pos_q   <= pos_inc;
						state_q <= S_IDLE;
					end
				end
				S_OUTRD: begin
					state_q <= S_OUTEM;
				end
				S_OUTEM: begin
					if (out_free) begin
						if (cnt_inc < len_q) begin
							cnt_q   <= cnt_inc;
							state_q <= S_OUTRD;
						end else begin
							state_q <= S_STAT;
						end
					end
				end
				S_STAT: begin
					if (out_free) begin
						sticky_q <= sticky_q | flag_q;
						phase_q  <= PH_IDLE;
						pos_q    <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/lmfe_ram.sv
`default_nettype none

module lmfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/lmfe_csum.sv
`default_nettype none

// Shared byte unit: end-around-carry add and byte compare.
module lmfe_csum (
	input  wire lmfe_pkg::alu_req_t req,
	output lmfe_pkg::alu_rsp_t      rsp
);

	logic [8:0] raw;

	assign raw = {1'b0, req.add_a} + {1'b0, req.add_b};

	// Fold the carry back in: a sum above 255 loses 255
	assign rsp.sum = raw[8] ? (raw[7:0] + lmfe_pkg::BYTE_ONE) : raw[7:0];
	assign rsp.eq  = (req.cmp_x == req.cmp_y);

endmodule

`default_nettype wire
